// ===== rtl/quaternion_product_and_rotate_macros.svh =====
// Assertion macros used by the quaternion unit.
`ifndef QUATERNION_PRODUCT_AND_ROTATE_MACROS_SVH
`define QUATERNION_PRODUCT_AND_ROTATE_MACROS_SVH

`ifndef SYNTHESIS
`define QPR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define QPR_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QPR_ASSERT(lbl, clk, rst, prop, msg)
`define QPR_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/qpr_pkg.sv =====
package qpr_pkg;

   typedef enum logic {
      CMD_PRODUCT = 1'b0,
      CMD_ROTATE  = 1'b1
   } cmd_type;

endpackage

// ===== rtl/qpr_req_if.sv =====
interface qpr_req_if #(
   parameter int DATA_WIDTH = 16
) ();
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic signed [DATA_WIDTH-1:0] a_w;
   logic signed [DATA_WIDTH-1:0] a_x;
   logic signed [DATA_WIDTH-1:0] a_y;
   logic signed [DATA_WIDTH-1:0] a_z;
   logic signed [DATA_WIDTH-1:0] b_w;
   logic signed [DATA_WIDTH-1:0] b_x;
   logic signed [DATA_WIDTH-1:0] b_y;
   logic signed [DATA_WIDTH-1:0] b_z;

   modport source (
      output valid, cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
      input  ready
   );

   modport sink (
      input  valid, cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
      output ready
   );
endinterface

// ===== rtl/qpr_rsp_if.sv =====
interface qpr_rsp_if #(
   parameter int DATA_WIDTH = 16
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] out_w;
   logic signed [DATA_WIDTH-1:0] out_x;
   logic signed [DATA_WIDTH-1:0] out_y;
   logic signed [DATA_WIDTH-1:0] out_z;

   modport source (
      output valid, out_w, out_x, out_y, out_z,
      input  ready
   );

   modport sink (
      input  valid, out_w, out_x, out_y, out_z,
      output ready
   );
endinterface

// ===== rtl/qpr_round_sat.sv =====
module qpr_round_sat
   import qpr_pkg::*;
#(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14,
   parameter int ACC_WIDTH  = 52
) (
   input  cmd_type                      mode,
   input  logic signed [ACC_WIDTH-1:0]  acc,
   output logic signed [DATA_WIDTH-1:0] result
);
   localparam int SW   = ACC_WIDTH + 1;
   localparam int SH_P = FRAC_BITS;
   localparam int SH_R = 2 * FRAC_BITS;

   localparam logic signed [SW-1:0] RND_P  = SW'(1) << (SH_P - 1);
   localparam logic signed [SW-1:0] RND_R  = SW'(1) << (SH_R - 1);
   localparam logic signed [SW-1:0] SAT_HI =
      {{(SW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] shifted;

   // Half an output step is added before the arithmetic shift, so ties round up.
   always_comb begin
      if (mode == CMD_ROTATE) begin
         sum     = SW'(acc) + RND_R;
         shifted = sum >>> SH_R;
      end else begin
         sum     = SW'(acc) + RND_P;
         shifted = sum >>> SH_P;
      end
   end

   always_comb begin
      if (shifted > SAT_HI) begin
         result = SAT_HI[DATA_WIDTH-1:0];
      end else if (shifted < SAT_LO) begin
         result = SAT_LO[DATA_WIDTH-1:0];
      end else begin
         result = shifted[DATA_WIDTH-1:0];
      end
   end
endmodule

// ===== rtl/quaternion_product_and_rotate.sv =====
// Fixed-point quaternion unit.
// The request channel carries a command and two quaternions a and b. Command
// product returns the Hamilton product a*b, each component rounded to nearest
// and saturated. Command rotate returns the vector (a_x,a_y,a_z) rotated as
// b*v*conj(b); the intermediate product is kept exact and only the final sums
// are rounded by twice the fraction width. out_w is zero for a rotation.
// Every request transfer gives exactly one response transfer, in order.
// The datapath is five register stages: operand multiply, first Hamilton sums,
// multiply by the rotation quaternion, second sums, and round with saturation
// into the output register. One request is taken every cycle while the
// response side is ready. When the receiver stalls, the whole pipeline holds
// and req_if.ready falls while the output register is full; nothing is lost
// or repeated. Reset clears all stage valid bits; the data and command
// registers are not reset.
`include "quaternion_product_and_rotate_macros.svh"

module quaternion_product_and_rotate
   import qpr_pkg::*;
#(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic      clock,
   input  logic      reset,
   qpr_req_if.sink   req_if,
   qpr_rsp_if.source rsp_if
);
   localparam int DW = DATA_WIDTH;
   localparam int PW = 2 * DW;
   localparam int TW = 2 * DW + 2;
   localparam int QW = 3 * DW + 2;
   localparam int RW = 3 * DW + 4;

   // Operand pairs of the second product t*conj(b), grouped by output component.
   localparam int TI [12] = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3};
   localparam int BI [12] = '{1, 0, 3, 2, 2, 3, 0, 1, 3, 2, 1, 0};

   logic advance;
   logic [3:0] stage_valid;

   // Stage 1
   logic                    s1_valid_in, s1_valid_ff;
   cmd_type                 s1_cmd_in, s1_cmd_ff;
   logic signed [DW-1:0]    p_op [4];
   logic signed [DW-1:0]    q_op [4];
   logic signed [DW-1:0]    s1_b_in [4];
   logic signed [DW-1:0]    s1_b_ff [4];
   logic signed [PW-1:0]    s1_prod_in [16];
   logic signed [PW-1:0]    s1_prod_ff [16];

   // Stage 2
   logic                    s2_valid_ff;
   cmd_type                 s2_cmd_ff;
   logic signed [DW-1:0]    s2_b_ff [4];
   logic signed [TW-1:0]    s2_t_in [4];
   logic signed [TW-1:0]    s2_t_ff [4];

   // Stage 3
   logic                    s3_valid_ff;
   cmd_type                 s3_cmd_ff;
   logic signed [TW-1:0]    s3_t_ff [4];
   logic signed [QW-1:0]    s3_mul_in [12];
   logic signed [QW-1:0]    s3_mul_ff [12];

   // Stage 4
   logic                    s4_valid_ff;
   cmd_type                 s4_cmd_ff;
   logic signed [RW-1:0]    s4_r_in [4];
   logic signed [RW-1:0]    s4_r_ff [4];

   // Stage 5 (output register)
   logic                    s5_valid_ff;
   cmd_type                 s5_cmd_ff;
   logic signed [DW-1:0]    rnd_out [4];
   logic signed [DW-1:0]    s5_out_in [4];
   logic signed [DW-1:0]    s5_out_ff [4];

   assign advance      = !s5_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;
   assign stage_valid  = {s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff};

   always_comb begin
      s1_valid_in = req_if.valid;
      s1_cmd_in   = cmd_type'(req_if.cmd);
      s1_b_in[0]  = req_if.b_w;
      s1_b_in[1]  = req_if.b_x;
      s1_b_in[2]  = req_if.b_y;
      s1_b_in[3]  = req_if.b_z;
      if (s1_cmd_in == CMD_ROTATE) begin
         p_op = s1_b_in;
         q_op[0] = '0;
         q_op[1] = req_if.a_x;
         q_op[2] = req_if.a_y;
         q_op[3] = req_if.a_z;
      end else begin
         p_op[0] = req_if.a_w;
         p_op[1] = req_if.a_x;
         p_op[2] = req_if.a_y;
         p_op[3] = req_if.a_z;
         q_op = s1_b_in;
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            s1_prod_in[4*i+j] = PW'(p_op[i]) * PW'(q_op[j]);
         end
      end
   end

   always_comb begin
      s2_t_in[0] = TW'(s1_prod_ff[0])  - TW'(s1_prod_ff[5])
                 - TW'(s1_prod_ff[10]) - TW'(s1_prod_ff[15]);
      s2_t_in[1] = TW'(s1_prod_ff[1])  + TW'(s1_prod_ff[4])
                 + TW'(s1_prod_ff[11]) - TW'(s1_prod_ff[14]);
      s2_t_in[2] = TW'(s1_prod_ff[2])  - TW'(s1_prod_ff[7])
                 + TW'(s1_prod_ff[8])  + TW'(s1_prod_ff[13]);
      s2_t_in[3] = TW'(s1_prod_ff[3])  + TW'(s1_prod_ff[6])
                 - TW'(s1_prod_ff[9])  + TW'(s1_prod_ff[12]);
   end

   always_comb begin
      for (int k = 0; k < 12; k++) begin
         s3_mul_in[k] = QW'(s2_t_ff[TI[k]]) * QW'(s2_b_ff[BI[k]]);
      end
   end

   // The conjugate's signs are folded into the sums.
   always_comb begin
      if (s3_cmd_ff == CMD_ROTATE) begin
         s4_r_in[0] = '0;
         s4_r_in[1] = - RW'(s3_mul_ff[0]) + RW'(s3_mul_ff[1])
                      - RW'(s3_mul_ff[2]) + RW'(s3_mul_ff[3]);
         s4_r_in[2] = - RW'(s3_mul_ff[4]) + RW'(s3_mul_ff[5])
                      + RW'(s3_mul_ff[6]) - RW'(s3_mul_ff[7]);
         s4_r_in[3] = - RW'(s3_mul_ff[8]) - RW'(s3_mul_ff[9])
                      + RW'(s3_mul_ff[10]) + RW'(s3_mul_ff[11]);
      end else begin
         for (int i = 0; i < 4; i++) begin
            s4_r_in[i] = RW'(s3_t_ff[i]);
         end
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_round
      qpr_round_sat #(
         .DATA_WIDTH (DW),
         .FRAC_BITS  (FRAC_BITS),
         .ACC_WIDTH  (RW)
      ) u_round_sat (
         .mode   (s4_cmd_ff),
         .acc    (s4_r_ff[g]),
         .result (rnd_out[g])
      );
   end

   always_comb begin
      s5_out_in = rnd_out;
      if (s4_cmd_ff == CMD_ROTATE) begin
         s5_out_in[0] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff  <= s1_cmd_in;
         s1_b_ff    <= s1_b_in;
         s1_prod_ff <= s1_prod_in;
         s2_cmd_ff  <= s1_cmd_ff;
         s2_b_ff    <= s1_b_ff;
         s2_t_ff    <= s2_t_in;
         s3_cmd_ff  <= s2_cmd_ff;
         s3_t_ff    <= s2_t_ff;
         s3_mul_ff  <= s3_mul_in;
         s4_cmd_ff  <= s3_cmd_ff;
         s4_r_ff    <= s4_r_in;
         s5_cmd_ff  <= s4_cmd_ff;
         s5_out_ff  <= s5_out_in;
      end
   end

   assign rsp_if.valid = s5_valid_ff;
   assign rsp_if.out_w = s5_out_ff[0];
   assign rsp_if.out_x = s5_out_ff[1];
   assign rsp_if.out_y = s5_out_ff[2];
   assign rsp_if.out_z = s5_out_ff[3];

   `QPR_ASSERT(a_accept_enters, clock, reset, req_if.valid && req_if.ready |=> s1_valid_ff, "accepted request did not enter stage 1")
   `QPR_ASSERT(a_stall_holds, clock, reset, !advance |=> $stable(stage_valid), "pipeline moved during a stall")
   `QPR_ASSERT(a_rotate_w_zero, clock, reset, s5_valid_ff && s5_cmd_ff == CMD_ROTATE |-> rsp_if.out_w == '0, "rotation result has nonzero w")
   `QPR_ASSERT_NR(a_reset_clears, clock, $past(reset) |-> !s5_valid_ff, "output valid after reset")
endmodule

// ===== test/qpr_checker.sv =====
module qpr_checker
   import qpr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   qpr_req_if   req_mon,
   qpr_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   results_checked
);

   localparam int DW   = 16;
   localparam int FRAC = 14;

   typedef logic [0:3][DW-1:0] quad_type;

   quad_type expected_outputs[$];

   initial begin
      fail_count      = 0;
      pending_count   = 0;
      results_checked = 0;
   end

   function automatic void hamilton_prod(input longint p[4], input longint q[4],
                                         output longint r[4]);
      r[0] = p[0] * q[0] - p[1] * q[1] - p[2] * q[2] - p[3] * q[3];
      r[1] = p[0] * q[1] + p[1] * q[0] + p[2] * q[3] - p[3] * q[2];
      r[2] = p[0] * q[2] - p[1] * q[3] + p[2] * q[0] + p[3] * q[1];
      r[3] = p[0] * q[3] + p[1] * q[2] - p[2] * q[1] + p[3] * q[0];
   endfunction

   // Ties round toward plus infinity because half a unit is added before the shift.
   function automatic logic [DW-1:0] round_sat(input longint acc, input int sh);
      longint v;
      v = (acc + (longint'(1) <<< (sh - 1))) >>> sh;
      if (v > (longint'(1) <<< (DW - 1)) - 1)
         v = (longint'(1) <<< (DW - 1)) - 1;
      else if (v < -(longint'(1) <<< (DW - 1)))
         v = -(longint'(1) <<< (DW - 1));
      return v[DW-1:0];
   endfunction

   function automatic quad_type quat_unit_result(input cmd_type cmd, input quad_type a,
                                                 input quad_type b);
      longint   p[4];
      longint   q[4];
      longint   v[4];
      longint   bc[4];
      longint   t[4];
      longint   r[4];
      quad_type res;
      for (int i = 0; i < 4; i++) begin
         p[i] = longint'($signed(a[i]));
         q[i] = longint'($signed(b[i]));
      end
      if (cmd == CMD_PRODUCT) begin
         hamilton_prod(p, q, r);
         for (int i = 0; i < 4; i++)
            res[i] = round_sat(r[i], FRAC);
      end else begin
         v[0] = 0;
         bc[0] = q[0];
         for (int i = 1; i < 4; i++) begin
            v[i] = p[i];
            bc[i] = -q[i];
         end
         hamilton_prod(q, v, t);
         hamilton_prod(t, bc, r);
         res[0] = '0;
         for (int i = 1; i < 4; i++)
            res[i] = round_sat(r[i], 2 * FRAC);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < 20)
         $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      quad_type got;
      quad_type exp_res;
      string names[4];
      names = '{"w", "x", "y", "z"};
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.out_w, rsp_mon.out_x, rsp_mon.out_y, rsp_mon.out_z};
            if (expected_outputs.size() == 0) begin
               report_mismatch($sformatf("response with no request pending, w=%0d x=%0d",
                                         $signed(got[0]), $signed(got[1])));
            end else begin
               exp_res = expected_outputs.pop_front();
               for (int i = 0; i < 4; i++) begin
                  if (got[i] !== exp_res[i])
                     report_mismatch($sformatf("response %0d out_%s got %0d expected %0d",
                                               results_checked, names[i],
                                               $signed(got[i]), $signed(exp_res[i])));
               end
            end
            results_checked <= results_checked + 1;
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_outputs.push_back(quat_unit_result(
               cmd_type'(req_mon.cmd),
               {req_mon.a_w, req_mon.a_x, req_mon.a_y, req_mon.a_z},
               {req_mon.b_w, req_mon.b_x, req_mon.b_y, req_mon.b_z}));
         end
      end
      pending_count <= expected_outputs.size();
   end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
   import qpr_pkg::*;

   localparam int DW          = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1600;

   typedef logic [0:3][DW-1:0] quad_type;

   logic clock = 1'b0;
   logic reset;
   logic stall_off;
   int   idle_pct;
   int   cycle_count = 0;
   int   fail_count;
   int   pending_count;
   int   results_checked;
   int   n_product = 0;
   int   n_rotate  = 0;

   always #2 clock = ~clock;

   qpr_req_if #(.DATA_WIDTH(DW)) req_ch ();
   qpr_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

   quaternion_product_and_rotate dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   qpr_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .results_checked (results_checked)
   );

   always @(posedge clock) begin
      rsp_ch.ready <= stall_off || ($urandom_range(99) >= 27);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic quad_type quat(input int w, input int x, input int y, input int z);
      return {DW'(w), DW'(x), DW'(y), DW'(z)};
   endfunction

   function automatic quad_type rand_quat(input int lim);
      quad_type q;
      for (int i = 0; i < 4; i++) begin
         if (lim >= 32768)
            q[i] = DW'($urandom);
         else
            q[i] = DW'(int'($urandom_range(2 * lim)) - lim);
      end
      return q;
   endfunction

   task automatic send_item(input cmd_type cmd, input quad_type a, input quad_type b);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= cmd;
      req_ch.a_w   <= a[0];
      req_ch.a_x   <= a[1];
      req_ch.a_y   <= a[2];
      req_ch.a_z   <= a[3];
      req_ch.b_w   <= b[0];
      req_ch.b_x   <= b[1];
      req_ch.b_y   <= b[2];
      req_ch.b_z   <= b[3];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (cmd == CMD_PRODUCT)
         n_product++;
      else
         n_rotate++;
   endtask

   initial begin
      int kind;
      reset        <= 1'b1;
      stall_off    <= 1'b0;
      idle_pct     = 27;
      req_ch.valid <= 1'b0;
      req_ch.cmd   <= CMD_PRODUCT;
      req_ch.a_w   <= '0;
      req_ch.a_x   <= '0;
      req_ch.a_y   <= '0;
      req_ch.a_z   <= '0;
      req_ch.b_w   <= '0;
      req_ch.b_x   <= '0;
      req_ch.b_y   <= '0;
      req_ch.b_z   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_item(CMD_PRODUCT, quat(0, 0, 0, 0), quat(0, 0, 0, 0));
      send_item(CMD_PRODUCT, quat(16384, 0, 0, 0), quat(16384, 0, 0, 0));
      send_item(CMD_PRODUCT, quat(32767, 32767, 32767, 32767),
                quat(32767, 32767, 32767, 32767));
      send_item(CMD_PRODUCT, quat(-32768, -32768, -32768, -32768),
                quat(-32768, -32768, -32768, -32768));
      send_item(CMD_PRODUCT, quat(32767, -32768, 32767, -32768),
                quat(-32768, 32767, 32767, -32768));
      // Exact half-unit results: the positive one rounds up, the negative one to zero.
      send_item(CMD_PRODUCT, quat(1, 0, 0, 0), quat(8192, 0, 0, 0));
      send_item(CMD_PRODUCT, quat(-1, 0, 0, 0), quat(8192, 0, 0, 0));
      send_item(CMD_PRODUCT, quat(0, 16384, 0, 0), quat(0, 0, 16384, 0));
      send_item(CMD_PRODUCT, quat(0, 0, 16384, 0), quat(0, 16384, 0, 0));
      send_item(CMD_ROTATE, quat(0, 0, 0, 0), quat(0, 0, 0, 0));
      send_item(CMD_ROTATE, quat(12345, 32767, 32767, -32768), quat(16384, 0, 0, 0));
      send_item(CMD_ROTATE, quat(0, 16384, 0, 0), quat(11585, 0, 0, 11585));
      send_item(CMD_ROTATE, quat(-7, 1000, -2000, 3000), quat(0, 16384, 0, 0));
      send_item(CMD_ROTATE, quat(32767, 32767, 32767, 32767),
                quat(32767, 32767, 32767, 32767));
      send_item(CMD_ROTATE, quat(-32768, -32768, -32768, -32768),
                quat(-32768, -32768, -32768, -32768));
      send_item(CMD_ROTATE, quat(0, 1, 1, 1), quat(32767, -32768, 32767, -32768));
      send_item(CMD_ROTATE, quat(0, 2, 0, 0), quat(8192, 0, 0, 0));
      send_item(CMD_ROTATE, quat(0, -2, 0, 0), quat(8192, 0, 0, 0));
      send_item(CMD_ROTATE, quat(-32768, 5, -32768, 32767), quat(11585, -11585, 0, 0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 700) begin
            idle_pct  = 0;
            stall_off <= 1'b1;
         end else if (n == 1000) begin
            idle_pct  = 27;
            stall_off <= 1'b0;
         end
         kind = $urandom_range(99);
         if (kind < 25)
            send_item(CMD_PRODUCT, rand_quat(32768), rand_quat(32768));
         else if (kind < 45)
            send_item(CMD_PRODUCT, rand_quat(16384), rand_quat(16384));
         else if (kind < 85)
            send_item(CMD_ROTATE, rand_quat(32768), rand_quat(11585));
         else
            send_item(CMD_ROTATE, rand_quat(32768), rand_quat(32768));
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d product and %0d rotation requests, %0d responses compared.",
               n_product, n_rotate, results_checked);
      $display("Operands covered full-range, moderate and near-unit quaternions.");
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/qpr_pkg.sv
rtl/qpr_req_if.sv
rtl/qpr_rsp_if.sv
rtl/qpr_round_sat.sv
rtl/quaternion_product_and_rotate.sv
test/qpr_checker.sv
test/tb_top.sv
